@@ rtl/mrrc_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the Modbus read reply checker.
package mrrc_pkg;

    localparam int unsigned RegCountW = 7;
    localparam int unsigned LenW      = 8;
    localparam logic [RegCountW-1:0] RegMax   = 7'd125;
    localparam logic [RegCountW-1:0] RegReset = 7'd1;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    typedef enum logic [1:0] {
        MODE_ARM     = 2'd0,
        MODE_BYTE    = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_RESP = 2'd1,
        ST_INCOMPL = 2'd2,
        ST_CRC_ERR = 2'd3
    } status_t;

    // Reflected CRC-16, one byte, unrolled over eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/modbus_read_reply_checker.sv @@
// Modbus RTU read-holding-registers reply checker, top level.
//
// Takes one request per cycle on s_axis unless m_axis back-pressure stalls it: tuser is the
// mode (arm, byte, timeout), tdata the received byte. After an arm request, each reply byte
// ahead of the trailing CRC runs through the CRC-16 (0xA001, start 0xFFFF); every completed
// big-endian register word is sent out right away as a tentative result, and once
// 5 + 2 * reg_count bytes are in, the trailing low-first CRC is compared and a status
// result with tlast set closes the reply. A timeout while armed reports no response or
// incomplete. A request sits in the input register, the CRC byte update and the bookkeeping
// run in a single combinational pass, and the result lands in the output register, so
// throughput is limited only by m_axis back-pressure. reg_count is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle, which the
// block does not enforce. 0 acts as 1 and values above 125 act as 125.
module modbus_read_reply_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [mrrc_pkg::RegCountW-1:0] cfg_wr_data,   // reg_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,    // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [6:0] reg_index, [22:7] reg_value, [24:23] status
    output logic        m_axis_tuser,    // [0] is_status
    output logic        m_axis_tlast     // [0] last
);
    import mrrc_pkg::*;

    // configuration
    logic [RegCountW-1:0] reg_count_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    mode_t       in_mode_reg;
    logic [7:0]  in_byte_reg;

    // reply state
    logic [15:0]     crc_reg, crc_next;
    logic [LenW-1:0] count_reg, count_next;
    logic [7:0]      high_reg, high_next;
    logic [7:0]      crc_low_reg, crc_low_next;
    logic            armed_reg, armed_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_is_status_reg;
    logic [RegCountW-1:0] out_index_reg;
    logic [15:0]          out_value_reg;
    status_t              out_status_reg;

    // pass result
    logic                 emit;
    logic                 res_is_status;
    logic [RegCountW-1:0] res_index;
    logic [15:0]          res_value;
    status_t              res_status;

    logic                 out_free;
    logic                 fire;
    logic [RegCountW-1:0] n_clamped;
    logic [LenW-1:0]      exp_len;
    logic [LenW:0]        pos_plus1;
    logic [LenW:0]        pos_plus2;
    logic [LenW-1:0]      pos_minus4;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign in_valid_next  = (s_axis_tvalid && s_axis_tready) || (in_valid_reg && !out_free);
    assign out_valid_next = (fire && emit) || (out_valid_reg && !m_axis_tready);

    always_comb begin
        if (reg_count_reg == '0) begin
            n_clamped = RegCountW'(1);
        end else if (reg_count_reg > RegMax) begin
            n_clamped = RegMax;
        end else begin
            n_clamped = reg_count_reg;
        end
        exp_len    = LenW'(5) + {n_clamped, 1'b0};
        pos_plus1  = {1'b0, count_reg} + (LenW+1)'(1);
        pos_plus2  = {1'b0, count_reg} + (LenW+1)'(2);
        pos_minus4 = count_reg - LenW'(4);
    end

    // single pass over one request
    always_comb begin
        crc_next      = crc_reg;
        count_next    = count_reg;
        high_next     = high_reg;
        crc_low_next  = crc_low_reg;
        armed_next    = armed_reg;
        emit          = 1'b0;
        res_is_status = 1'b0;
        res_index     = '0;
        res_value     = '0;
        res_status    = ST_OK;
        case (in_mode_reg)
            MODE_ARM: begin
                crc_next     = CrcInit;
                count_next   = '0;
                high_next    = '0;
                crc_low_next = '0;
                armed_next   = 1'b1;
            end
            MODE_TIMEOUT: begin
                if (armed_reg) begin
                    armed_next    = 1'b0;
                    emit          = 1'b1;
                    res_is_status = 1'b1;
                    res_status    = (count_reg == '0) ? ST_NO_RESP : ST_INCOMPL;
                end
            end
            MODE_BYTE: begin
                if (armed_reg) begin
                    count_next = pos_plus1[LenW-1:0];
                    if (pos_plus1 >= {1'b0, exp_len}) begin
                        armed_next    = 1'b0;
                        emit          = 1'b1;
                        res_is_status = 1'b1;
                        res_status    = ({in_byte_reg, crc_low_reg} == crc_reg) ?
                                        ST_OK : ST_CRC_ERR;
                    end else if (pos_plus2 == {1'b0, exp_len}) begin
                        crc_low_next = in_byte_reg;
                    end else begin
                        crc_next = crc_byte(crc_reg, in_byte_reg);
                        if (count_reg >= LenW'(3)) begin
                            // odd position holds the high byte, even one completes the word
                            if (count_reg[0]) begin
                                high_next = in_byte_reg;
                            end else begin
                                emit      = 1'b1;
                                res_index = pos_minus4[RegCountW:1];
                                res_value = {high_reg, in_byte_reg};
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_count_reg <= RegReset;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CrcInit;
            count_reg     <= '0;
            high_reg      <= '0;
            crc_low_reg   <= '0;
            armed_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                reg_count_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                crc_reg     <= crc_next;
                count_reg   <= count_next;
                high_reg    <= high_next;
                crc_low_reg <= crc_low_next;
                armed_reg   <= armed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_mode_reg <= mode_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata;
        end
        if (fire && emit) begin
            out_is_status_reg <= res_is_status;
            out_index_reg     <= res_index;
            out_value_reg     <= res_value;
            out_status_reg    <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_is_status_reg;
    assign m_axis_tlast  = out_is_status_reg;
    assign m_axis_tdata  = {7'd0, out_status_reg, out_value_reg, out_index_reg};

`ifndef SYNTHESIS
    // a stalled request must stay in the input register
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input request dropped while output stalled");

    // an arm request leaves the block armed
    a_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_mode_reg == MODE_ARM |=> armed_reg && count_reg == '0)
        else $error("arm request did not arm");

    // a result is only produced while armed, and a status result disarms
    a_status_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit && res_is_status |=> !armed_reg && out_valid_reg)
        else $error("status result did not disarm");

    a_word_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[24:23] == 2'd0)
        else $error("word result carries a status");
`endif

endmodule
